[src/nsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, constants and helpers of the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int unsigned NscBufferBytes = 80;
  localparam int unsigned NscLenW        = 7;
  localparam int unsigned NscTypeW       = 4;
  localparam int unsigned NscHdrBytes    = 5;
  localparam int unsigned NscHdrIdxW     = 3;
  localparam int unsigned NscKinds       = 13;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_BAD_HEX   = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_BODY = 2'd0,
    PH_DIG1 = 2'd1,
    PH_DIG2 = 2'd2,
    PH_IDLE = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [NscTypeW-1:0] sentence_type;
    logic [NscLenW-1:0]  body_length;
  } out_beat_t;

  // result handed from the parser to the output buffer
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  // three-letter sentence kinds after "GP"; entry k gives type k+1
  localparam logic [23:0] KINDS [NscKinds] = '{
    24'h474741, 24'h565447, 24'h524D43, 24'h474C4C,
    24'h475341, 24'h475356, 24'h484454, 24'h5A4441,
    24'h523030, 24'h524D41, 24'h424F44, 24'h425743,
    24'h524D42
  };

  // bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  function automatic logic [NscTypeW-1:0] classify(
    input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] h2,
    input logic [7:0] h3, input logic [7:0] h4);
    logic [NscTypeW-1:0] t;
    t = '0;
    if (h0 == ChG && h1 == ChP) begin
      for (int k = NscKinds - 1; k >= 0; k--) begin
        if ({h2, h3, h4} == KINDS[k]) t = NscTypeW'(k + 1);
      end
    end
    return t;
  endfunction

endpackage

[src/nsc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_in_if / nsc_out_if
// Valid/ready channels of the checker: received bytes in, results out.
// ----------------------------------------------------------------------------
interface nsc_in_if
  import nsc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nsc_out_if
  import nsc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/nsc_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_parser
// Sentence state, running XOR, body count and header; one byte per beat.
// ----------------------------------------------------------------------------
module nsc_parser
  import nsc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = NscBufferBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] rx_byte_i,
  output res_t       res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_BYTES);
  localparam logic [CntW-1:0] HdrLen = CntW'(NscHdrBytes);

  phase_e          phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [3:0]      chk_hi_q, chk_hi_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      hdr_q [NscHdrBytes];
  logic            hdr_we;

  logic       restart;
  logic [4:0] hv;
  logic       bad_hex;
  logic [7:0] chk_full;

  assign restart  = (rx_byte_i == ChDollar) || (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
  assign hv       = hex_value(rx_byte_i);
  assign bad_hex  = hv[4];
  assign chk_full = {chk_hi_q, hv[3:0]};

  // next state
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (restart) begin
        phase_d = PH_BODY;
      end else begin
        case (phase_q)
          PH_BODY: if (rx_byte_i == ChStar) phase_d = PH_DIG1;
          PH_DIG1: phase_d = bad_hex ? PH_BODY : PH_DIG2;
          PH_DIG2: phase_d = PH_BODY;
          PH_IDLE: phase_d = PH_IDLE;
          default: phase_d = PH_BODY;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    xor_d      = xor_q;
    chk_hi_d   = chk_hi_q;
    cnt_d      = cnt_q;
    hdr_we     = 1'b0;
    res_o      = '0;
    res_o.beat.body_length = NscLenW'(cnt_q);
    if (fire_i) begin
      if (restart) begin
        xor_d = '0;
        cnt_d = '0;
      end else begin
        case (phase_q)
          PH_BODY: begin
            if (rx_byte_i != ChStar) begin
              xor_d = xor_q ^ rx_byte_i;
              if (cnt_q < CntMax) begin
                hdr_we = (cnt_q < HdrLen);
                cnt_d  = cnt_q + 1'b1;
              end
            end
          end
          PH_DIG1, PH_DIG2: begin
            if (bad_hex) begin
              res_o.valid       = 1'b1;
              res_o.beat.status = ST_BAD_HEX;
              cnt_d             = '0;
            end else if (phase_q == PH_DIG1) begin
              chk_hi_d = hv[3:0];
            end else begin
              res_o.valid = 1'b1;
              cnt_d       = '0;
              if (chk_full != xor_q) begin
                res_o.beat.status = ST_MISMATCH;
              end else if (cnt_q < HdrLen) begin
                res_o.beat.status = ST_TOO_SHORT;
              end else begin
                res_o.beat.status        = ST_VALID;
                res_o.beat.sentence_type = classify(hdr_q[0], hdr_q[1], hdr_q[2],
                                                    hdr_q[3], hdr_q[4]);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BODY;
      xor_q    <= '0;
      chk_hi_q <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      xor_q    <= xor_d;
      chk_hi_q <= chk_hi_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[cnt_q[NscHdrIdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

[src/nsc_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_out_buf
// Two-entry result buffer; keeps input moving under output stalls until full.
// ----------------------------------------------------------------------------
module nsc_out_buf
  import nsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_t      res_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_beat_t beat_o
);

  out_beat_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push    = res_i.valid;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign beat_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= res_i.beat;
    end
  end

endmodule

[src/nmea_sentence_checker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// NMEA 0183 sentence checker: running XOR, hex checksum and header decode.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 beat
//  in_i     in   rx_byte[7:0]                            one serial character
//  out_o    out  status[1:0] sentence_type[3:0]          one sentence result
//                body_length[6:0]
//
//  One byte per cycle while the output buffer has space: the parser updates its
//  state on the accepting edge and a result, if any, lands in a two-entry
//  output buffer on that same edge.
//  Async active-low reset clears the phase, XOR, checksum nibble and count.
//  in_i.ready drops only when both buffer entries hold untaken results.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_core
  import nsc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = NscBufferBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsc_in_if.sink    in_i,
  nsc_out_if.source out_o
);

  logic fire;
  res_t res;
  logic space;

  assign in_i.ready = space;
  assign fire       = in_i.valid && space;

  nsc_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .rx_byte_i(in_i.payload.rx_byte),
    .res_o    (res)
  );

  nsc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .space_o(space),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .beat_o (out_o.payload)
  );

  // a result is produced only by an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) res.valid |-> fire)
    else $error("result without accepted byte");

  // only a clean checksum carries a sentence type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.status != ST_VALID) |-> (out_o.payload.sentence_type == '0))
    else $error("type set on failed sentence");

  // reported length never exceeds the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.body_length <= NscLenW'(BUFFER_BYTES)))
    else $error("body length above buffer size");

  // a stalled result keeps its place until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.payload)))
    else $error("pending result lost");

endmodule

[tb/tb_nmea_sentence_checker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker_core
// Byte-stream test of the NMEA sentence checker. The stimulus side sends
// directed sentences, then a long random stream of mostly well-formed
// sentences with noise, restarts and broken checksums. A byte-level model
// predicts each result, and a checker process compares every output beat
// in order. Both handshakes idle at random, and one long receiver hold-off
// fills the output buffer so that the input stalls.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker_core;
  import nsc_pkg::*;

  localparam int unsigned ResetCycles = 12;
  localparam int unsigned MaxIdle     = 10;
  localparam int unsigned RandomBytes = 1840;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 40;

  typedef struct {
    status_e             status;
    logic [NscTypeW-1:0] kind;
    logic [NscLenW-1:0]  length;
  } sentence_result_t;

  logic clk_i;
  logic rst_ni;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  nmea_sentence_checker_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // sentence kinds after "GP"; entry k is type k+1
  string kind_names [NscKinds] = '{
    "GGA", "VTG", "RMC", "GLL", "GSA", "GSV", "HDT",
    "ZDA", "R00", "RMA", "BOD", "BWC", "RMB"
  };

  sentence_result_t   expected_results [$];
  phase_e             nmea_phase;
  logic [7:0]         run_xor;
  logic [7:0]         rx_sum;
  logic [NscLenW-1:0] body_cnt;
  logic [7:0]         hdr_bytes [NscHdrBytes];

  int   mismatch_count = 0;
  int   bytes_sent     = 0;
  bit   tx_idle_on     = 1'b1;
  bit   rx_idle_on     = 1'b1;
  int   hold_cycles    = 0;
  logic rx_hold        = 1'b0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // bit 4 set: not a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= "0" && c <= "9") v = 5'(c - "0");
    else if (c >= "a" && c <= "f") v = 5'(c - "a" + 10);
    else if (c >= "A" && c <= "F") v = 5'(c - "A" + 10);
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic logic [NscTypeW-1:0] header_kind();
    logic [NscTypeW-1:0] t;
    t = '0;
    if (hdr_bytes[0] == ChG && hdr_bytes[1] == ChP) begin
      for (int k = 0; k < NscKinds; k++) begin
        if (t == '0 && hdr_bytes[2] == kind_names[k][0] &&
            hdr_bytes[3] == kind_names[k][1] && hdr_bytes[4] == kind_names[k][2])
          t = NscTypeW'(k + 1);
      end
    end
    return t;
  endfunction

  function automatic bit is_restart(input logic [7:0] c);
    return c == ChDollar || c == ChCr || c == ChLf;
  endfunction

  task automatic clear_sentence_model();
    nmea_phase = PH_BODY;
    run_xor    = '0;
    rx_sum     = '0;
    body_cnt   = '0;
    for (int i = 0; i < NscHdrBytes; i++) hdr_bytes[i] = '0;
  endtask

  // advance the sentence model by one accepted byte
  task automatic predict_byte(input logic [7:0] b);
    sentence_result_t r;
    logic [4:0]       v;
    if (is_restart(b)) begin
      nmea_phase = PH_BODY;
      run_xor    = '0;
      body_cnt   = '0;
    end else if (nmea_phase == PH_BODY) begin
      if (b == ChStar) begin
        nmea_phase = PH_DIG1;
      end else begin
        run_xor ^= b;
        if (body_cnt < NscBufferBytes) begin
          if (body_cnt < NscHdrBytes) hdr_bytes[body_cnt[NscHdrIdxW-1:0]] = b;
          body_cnt++;
        end
      end
    end else if (nmea_phase == PH_DIG1 || nmea_phase == PH_DIG2) begin
      v = digit_value(b);
      r.kind   = '0;
      r.length = body_cnt;
      if (v[4]) begin
        r.status = ST_BAD_HEX;
        expected_results.push_back(r);
        nmea_phase = PH_BODY;
        body_cnt   = '0;
      end else if (nmea_phase == PH_DIG1) begin
        rx_sum     = {v[3:0], 4'h0};
        nmea_phase = PH_DIG2;
      end else begin
        rx_sum[3:0] = v[3:0];
        if (rx_sum != run_xor) begin
          r.status = ST_MISMATCH;
        end else if (body_cnt < NscHdrBytes) begin
          r.status = ST_TOO_SHORT;
        end else begin
          r.status = ST_VALID;
          r.kind   = header_kind();
        end
        expected_results.push_back(r);
        // running XOR deliberately kept until the next restart byte
        nmea_phase = PH_BODY;
        body_cnt   = '0;
      end
    end
  endtask

  // call at a rising edge; returns at the edge that accepts the beat
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.payload.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_checksum(input logic [7:0] sum, input bit lower);
    send_byte(ChStar);
    send_byte(hex_char(sum[7:4], lower));
    send_byte(hex_char(sum[3:0], lower));
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (is_restart(c) || c == ChStar);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom_range(0, 255));
      v = digit_value(c);
    end while (!v[4]);
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_known_kind();
    send_byte(ChDollar);
    send_text("GPGGA");
    send_checksum(run_xor, 1'b0);
    // bad digit in the second position, full header
    send_byte(ChDollar);
    send_text("GPBWC*4g");
  endtask

  task automatic test_bad_first_digit();
    send_byte(ChCr);
    send_text("GP**");
  endtask

  task automatic test_xor_carry();
    // no restart: XOR of "GP" survives the bad digit above
    send_byte(8'hFF);
    send_byte(8'h00);
    send_checksum(run_xor, 1'b1);
  endtask

  task automatic test_mismatch();
    send_byte(ChLf);
    send_text("GPRMB");
    send_checksum(run_xor ^ 8'h01, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_cycles <= HoldCycles;
    tx_idle_on = 1'b0;
    repeat (8) begin
      send_byte(ChDollar);
      send_text("GPVTG");
      send_checksum(run_xor, 1'b0);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic send_random_sentence();
    int         lead;
    int         shape;
    int         extra;
    int         mode;
    logic [7:0] sum;
    lead = $urandom_range(0, 9);
    if (lead <= 5) send_byte(ChDollar);
    else if (lead == 6) send_byte(ChCr);
    else if (lead == 7) send_byte(ChLf);
    else if (lead == 9) begin
      send_byte(ChCr);
      send_byte(ChLf);
      send_byte(ChDollar);
    end
    shape = $urandom_range(0, NscKinds + 2);
    if (shape < NscKinds) begin
      send_byte(ChG);
      send_byte(ChP);
      send_text(kind_names[shape]);
    end else if (shape == NscKinds) begin
      repeat (5) send_byte(8'($urandom_range(8'h41, 8'h5A)));
    end else if (shape == NscKinds + 1) begin
      send_byte(ChG);
      send_byte(ChP);
      repeat (3) send_byte(8'($urandom_range(8'h30, 8'h5A)));
    end else begin
      repeat ($urandom_range(0, 4)) send_byte(body_byte());
    end
    if (shape == NscKinds + 2) extra = 0;
    else if ($urandom_range(0, 39) == 0) extra = $urandom_range(70, 90);
    else extra = $urandom_range(0, 8);
    repeat (extra) send_byte(body_byte());
    sum  = run_xor;
    mode = $urandom_range(0, 9);
    if (mode == 7) sum ^= 8'($urandom_range(1, 255));
    send_byte(ChStar);
    if (mode == 8) begin
      send_byte(non_hex_byte());
    end else begin
      send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
      if (mode == 9) send_byte(non_hex_byte());
      else send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_random_stream();
    int stop_at;
    int n;
    stop_at = bytes_sent + RandomBytes;
    n       = 0;
    while (bytes_sent < stop_at) begin
      if (n % 25 == 0) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      send_random_sentence();
      n++;
    end
  endtask

  // ------------------------------------------------------------ processes

  initial begin : stimulus
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    rst_ni        <= 1'b0;
    clear_sentence_model();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_known_kind();
    test_bad_first_digit();
    test_xor_carry();
    test_mismatch();
    test_backpressure();
    test_random_stream();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("** nmea_sentence_checker_core: PASSED **");
    end else begin
      $display("** nmea_sentence_checker_core: FAILED **");
    end
    $finish;
  end

  // long receiver hold-off, counted down here
  initial begin : rx_hold_timer
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        rx_hold     <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        rx_hold <= 1'b0;
      end
    end
  end

  initial begin : result_checker
    sentence_result_t exp_r;
    int               rx_wait;
    out_ch.ready <= 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status=%0d type=%0d len=%0d",
                                    out_ch.payload.status, out_ch.payload.sentence_type,
                                    out_ch.payload.body_length));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.payload.status !== exp_r.status ||
              out_ch.payload.sentence_type !== exp_r.kind ||
              out_ch.payload.body_length !== exp_r.length)
            report_mismatch($sformatf(
              "status %0d/%0d type %0d/%0d len %0d/%0d (got/exp)",
              out_ch.payload.status, exp_r.status,
              out_ch.payload.sentence_type, exp_r.kind,
              out_ch.payload.body_length, exp_r.length));
        end
        rx_wait = rx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (rx_hold || rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        if (rx_wait > 0) rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall = 0;
      else stall++;
    end
    $display("[%0t] watchdog: no beat accepted for %0d cycles", $time, StallLimit);
    $display("** nmea_sentence_checker_core: FAILED **");
    $finish;
  end

endmodule
